// ===== rtl/scpa_pkg.sv =====
package scpa_pkg;

  localparam int GRANULE    = 8;
  localparam int MAX_SMALL  = 128;
  localparam int LINK_AW    = 13;
  localparam int LINK_DEPTH = 1 << LINK_AW;

  localparam logic [2:0] ST_ALLOC      = 3'd0;
  localparam logic [2:0] ST_FREED      = 3'd1;
  localparam logic [2:0] ST_BADSIZE    = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd3;
  localparam logic [2:0] ST_MISALIGNED = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] req_size;
    logic [15:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] block_addr;
    logic [2:0]  status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       eval;
    logic       bump_wr;
    logic       pop_wr;
    logic       div_step;
    logic       push_wr;
    logic       respond;
    logic       use_pop;
    logic [2:0] code;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic head_valid;
    logic bump_fits;
    logic free_pre_ok;
    logic div_done;
    logic rem_zero;
  } dp_stat_t;

endpackage

// ===== rtl/size_class_pool_allocator.sv =====
// Size-class pool allocator: allocate or free one small block per request.
// Input channel: request is taken at a clock edge where start is high and
// busy is low. kind 0 allocates req_size bytes (1..128, classes of 8-byte
// steps); kind 1 frees free_addr back onto its class's free list.
// Output channel: result is valid for exactly one cycle while done is high.
// The receiver cannot stall; a result must be taken when done is shown.
// Path from the accepting edge to done, by controller state:
//   allocate by bump or any failure decoded up front: S_EVAL responds
//   allocate popped from a free list: S_EVAL, then S_POP (one link memory read)
//   free: S_EVAL, then S_DIV until the block-size alignment check ends; the check
//   runs a shared remainder unit one bit per cycle
// busy drops together with the edge that loads the result, so a new
// request can be taken while done is high.
// Reset clears every class's bump offset and list head; the link memory
// needs no clearing since a list only reaches links it has written.
module size_class_pool_allocator #(
  parameter int NUM_CLASSES = 16,
  parameter int CLASS_BYTES = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  scpa_pkg::req_t request,
  output scpa_pkg::rsp_t result,
  output logic           done
);

  scpa_pkg::dp_cmd_t  cmd;
  scpa_pkg::dp_stat_t stat;

  scpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  scpa_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLASS_BYTES (CLASS_BYTES)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a request was taken");

  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result delivered in the cycle after acceptance");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != scpa_pkg::ST_ALLOC) |-> (result.block_addr == 16'd0))
    else $error("nonzero address on a non-allocation result");

endmodule

// ===== rtl/scpa_ctrl.sv =====
module scpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  scpa_pkg::dp_stat_t stat,
  output scpa_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = scpa_pkg::ST_ALLOC;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_IDLE;
        if (!stat.is_free) begin
          priority if (stat.bad_size) begin
            cmd.respond = 1'b1;
            cmd.code    = scpa_pkg::ST_BADSIZE;
          end else if (stat.head_valid) begin
            state_next = S_POP;
          end else if (stat.bump_fits) begin
            cmd.bump_wr = 1'b1;
            cmd.respond = 1'b1;
            cmd.code    = scpa_pkg::ST_ALLOC;
          end else begin
            cmd.respond = 1'b1;
            cmd.code    = scpa_pkg::ST_EXHAUSTED;
          end
        end else if (stat.free_pre_ok) begin
          state_next = S_DIV;
        end else begin
          cmd.respond = 1'b1;
          cmd.code    = scpa_pkg::ST_MISALIGNED;
        end
      end
      S_POP: begin
        cmd.pop_wr  = 1'b1;
        cmd.respond = 1'b1;
        cmd.use_pop = 1'b1;
        cmd.code    = scpa_pkg::ST_ALLOC;
        state_next  = S_IDLE;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
          if (stat.rem_zero) begin
            cmd.push_wr = 1'b1;
            cmd.code    = scpa_pkg::ST_FREED;
          end else begin
            cmd.code    = scpa_pkg::ST_MISALIGNED;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/scpa_datapath.sv =====
module scpa_datapath #(
  parameter int NUM_CLASSES = 16,
  parameter int CLASS_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  scpa_pkg::req_t     request,
  input  scpa_pkg::dp_cmd_t  cmd,
  output scpa_pkg::dp_stat_t stat,
  output scpa_pkg::rsp_t     result,
  output logic               done
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int OFS_W = $clog2(CLASS_BYTES);
  localparam int QW    = OFS_W - 3;
  localparam int CNT_W = $clog2(QW + 1);

  scpa_pkg::req_t req_q;

  logic [16:0]      list_head [NUM_CLASSES];
  logic [OFS_W-1:0] bump_offset [NUM_CLASSES];
  logic [16:0]      link_store [scpa_pkg::LINK_DEPTH];
  logic [16:0]      link_rdata;

  logic [3:0]       cls_q;
  logic [15:0]      pop_addr_q;
  logic [4:0]       rem;
  logic [QW-1:0]    dvd;
  logic [CNT_W-1:0] cnt;

  // allocate decode
  logic [7:0]       size_m1;
  logic [3:0]       acls;
  logic [CLS_W-1:0] aidx;
  logic [7:0]       bsize;
  logic             a_range;
  logic [16:0]      ahead;
  logic [OFS_W-1:0] abump;
  logic [15:0]      bump_addr;

  // free decode
  logic [4:0]       fcls;
  logic             f_range;
  logic [15:0]      fbase;
  logic [OFS_W-1:0] fofs;

  logic [CLS_W-1:0] qidx;
  logic [4:0]       divisor;
  logic [5:0]       trial;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
  end

  assign size_m1 = 8'(req_q.req_size - 16'd1);
  assign acls    = size_m1[6:3];
  assign aidx    = CLS_W'(acls);
  assign bsize   = 8'((5'(acls) + 5'd1) * 5'(scpa_pkg::GRANULE));
  assign a_range = (5'(acls) < 5'(NUM_CLASSES));
  assign ahead   = list_head[aidx];
  assign abump   = bump_offset[aidx];
  assign bump_addr = 16'(acls) * 16'(CLASS_BYTES) + 16'(abump);

  always_comb begin
    fcls = '0;
    for (int k = 1; k <= NUM_CLASSES; k++) begin
      if ({16'd0, req_q.free_addr} >= 32'(k) * 32'(CLASS_BYTES)) begin
        fcls = 5'(k);
      end
    end
  end

  assign f_range = (fcls < 5'(NUM_CLASSES));
  assign fbase   = 16'(fcls[3:0]) * 16'(CLASS_BYTES);
  assign fofs    = OFS_W'(req_q.free_addr - fbase);

  always_comb begin
    stat             = '0;
    stat.is_free     = (req_q.kind == scpa_pkg::KIND_FREE);
    stat.bad_size    = (req_q.req_size == 16'd0) ||
                       (req_q.req_size > 16'(scpa_pkg::MAX_SMALL)) || !a_range;
    stat.head_valid  = a_range && ahead[16];
    stat.bump_fits   = (18'(abump) + 18'(bsize)) < 18'(CLASS_BYTES);
    stat.free_pre_ok = f_range && (fofs[2:0] == 3'd0);
    stat.div_done    = (cnt == '0);
    stat.rem_zero    = (rem == 5'd0);
  end

  assign qidx    = CLS_W'(cls_q);
  assign divisor = 5'(cls_q) + 5'd1;
  assign trial   = {rem, dvd[QW-1]};

  // (offset / 8) mod (class + 1), one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      cls_q      <= (req_q.kind == scpa_pkg::KIND_FREE) ? fcls[3:0] : acls;
      pop_addr_q <= ahead[15:0];
      rem        <= '0;
      dvd        <= fofs[OFS_W-1:3];
      cnt        <= CNT_W'(QW);
    end else if (cmd.div_step) begin
      rem <= (trial >= {1'b0, divisor}) ? 5'(trial - {1'b0, divisor}) : trial[4:0];
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      link_rdata <= link_store[ahead[15:3]];
    end
    if (cmd.push_wr) begin
      link_store[req_q.free_addr[15:3]] <= list_head[qidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        list_head[i]   <= '0;
        bump_offset[i] <= '0;
      end
    end else begin
      if (cmd.bump_wr) begin
        bump_offset[aidx] <= OFS_W'(abump + OFS_W'(bsize));
      end
      if (cmd.pop_wr) begin
        list_head[qidx] <= link_rdata;
      end else if (cmd.push_wr) begin
        list_head[qidx] <= {1'b1, req_q.free_addr};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      result.status <= cmd.code;
      if (cmd.code == scpa_pkg::ST_ALLOC) begin
        result.block_addr <= cmd.use_pop ? pop_addr_q : bump_addr;
      end else begin
        result.block_addr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CLASSES = 16;
  localparam int CLASS_BYTES = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  scpa_pkg::req_t request = '0;
  scpa_pkg::rsp_t result;

  size_class_pool_allocator #(
    .NUM_CLASSES(NUM_CLASSES),
    .CLASS_BYTES(CLASS_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result(result),
    .done(done)
  );

  always #5 clk = ~clk;

  // allocator state as the testbench sees it
  int          bump_off [NUM_CLASSES];
  logic [16:0] free_head [NUM_CLASSES];
  logic [16:0] next_link [scpa_pkg::LINK_DEPTH];

  scpa_pkg::rsp_t pending_results[$];
  logic [15:0]    held_blocks[$];
  int             mismatch_count = 0;
  int             no_gap_left = 0;

  function automatic scpa_pkg::rsp_t compute_block_result(scpa_pkg::req_t r);
    scpa_pkg::rsp_t o;
    int             cls;
    int             bsize;
    int             off;
    logic [15:0]    a;
    o = '0;
    if (r.kind == scpa_pkg::KIND_ALLOC) begin
      if (r.req_size == 0 || int'(r.req_size) > scpa_pkg::MAX_SMALL) begin
        o.status = scpa_pkg::ST_BADSIZE;
      end else begin
        cls = (int'(r.req_size) - 1) / scpa_pkg::GRANULE;
        bsize = (cls + 1) * scpa_pkg::GRANULE;
        if (cls >= NUM_CLASSES) begin
          o.status = scpa_pkg::ST_BADSIZE;
        end else if (free_head[cls][16]) begin
          a = free_head[cls][15:0];
          free_head[cls] =
            next_link[(int'(a) / scpa_pkg::GRANULE) % scpa_pkg::LINK_DEPTH];
          o.block_addr = a;
          o.status = scpa_pkg::ST_ALLOC;
        end else if (bump_off[cls] + bsize < CLASS_BYTES) begin
          o.block_addr = 16'(cls * CLASS_BYTES + bump_off[cls]);
          bump_off[cls] += bsize;
          o.status = scpa_pkg::ST_ALLOC;
        end else begin
          o.status = scpa_pkg::ST_EXHAUSTED;
        end
      end
    end else begin
      cls = int'(r.free_addr) / CLASS_BYTES;
      off = int'(r.free_addr) % CLASS_BYTES;
      if (cls >= NUM_CLASSES) begin
        o.status = scpa_pkg::ST_MISALIGNED;
      end else if (off % ((cls + 1) * scpa_pkg::GRANULE) != 0) begin
        o.status = scpa_pkg::ST_MISALIGNED;
      end else begin
        next_link[(int'(r.free_addr) / scpa_pkg::GRANULE) % scpa_pkg::LINK_DEPTH] =
          free_head[cls];
        free_head[cls] = {1'b1, r.free_addr};
        o.status = scpa_pkg::ST_FREED;
      end
    end
    return o;
  endfunction

  // unused field carries random bits
  function automatic scpa_pkg::req_t alloc_req(int size);
    scpa_pkg::req_t r;
    r.kind = scpa_pkg::KIND_ALLOC;
    r.req_size = 16'(size);
    r.free_addr = 16'($urandom);
    return r;
  endfunction

  function automatic scpa_pkg::req_t free_req(logic [15:0] addr);
    scpa_pkg::req_t r;
    r.kind = scpa_pkg::KIND_FREE;
    r.req_size = 16'($urandom);
    r.free_addr = addr;
    return r;
  endfunction

  task automatic issue_request(input scpa_pkg::req_t r, output scpa_pkg::rsp_t exp);
    int gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(5, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    exp = compute_block_result(r);
    pending_results.push_back(exp);
    if (r.kind == scpa_pkg::KIND_ALLOC && exp.status == scpa_pkg::ST_ALLOC)
      held_blocks.push_back(exp.block_addr);
  endtask

  always @(posedge clk) begin
    scpa_pkg::rsp_t exp;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request outstanding: block_addr %h status %0d",
                 $time, result.block_addr, result.status);
      end else begin
        exp = pending_results.pop_front();
        if (result.block_addr !== exp.block_addr) begin
          mismatch_count++;
          $display("%0t: block_addr expected %h got %h",
                   $time, exp.block_addr, result.block_addr);
        end
        if (result.status !== exp.status) begin
          mismatch_count++;
          $display("%0t: status expected %0d got %0d", $time, exp.status, result.status);
        end
      end
    end
  end

  task automatic test_alloc_edges();
    scpa_pkg::rsp_t e;
    issue_request(alloc_req(1), e);   // first block of class 0 is address zero
    issue_request(alloc_req(8), e);
    issue_request(alloc_req(9), e);
    issue_request(alloc_req(128), e);
    issue_request(alloc_req(127), e);
    issue_request(alloc_req(64), e);
    issue_request(alloc_req(120), e);
  endtask

  task automatic test_bad_sizes();
    scpa_pkg::rsp_t e;
    issue_request(alloc_req(0), e);
    issue_request(alloc_req(129), e);
    issue_request(alloc_req(16'hFFFF), e);
    issue_request(alloc_req(16'h8000), e);
    issue_request(alloc_req(16'h0100), e);
  endtask

  task automatic test_free_reuse();
    scpa_pkg::rsp_t e;
    issue_request(free_req(16'h0000), e);
    issue_request(alloc_req(5), e);
    // last block of class 15, never given out by bump
    issue_request(free_req(16'hFF80), e);
    issue_request(alloc_req(128), e);
    // double free in class 1: list becomes a self loop
    issue_request(alloc_req(16), e);
    issue_request(free_req(16'h1000), e);
    issue_request(free_req(16'h1000), e);
    issue_request(alloc_req(16), e);
    issue_request(alloc_req(11), e);
  endtask

  task automatic test_misaligned_frees();
    scpa_pkg::rsp_t e;
    issue_request(free_req(16'h0001), e);
    issue_request(free_req(16'h1008), e);
    issue_request(free_req(16'hF040), e);
    issue_request(free_req(16'hFFFF), e);
    issue_request(free_req(16'h8004), e);
  endtask

  task automatic test_exhaust_class(int cls);
    scpa_pkg::rsp_t e;
    do begin
      issue_request(alloc_req($urandom_range(cls * scpa_pkg::GRANULE + 1,
                                             cls * scpa_pkg::GRANULE + scpa_pkg::GRANULE)),
                    e);
    end while (e.status != scpa_pkg::ST_EXHAUSTED);
    issue_request(alloc_req(cls * scpa_pkg::GRANULE + 1), e);
    issue_request(free_req(16'(cls * CLASS_BYTES)), e);
    issue_request(alloc_req(cls * scpa_pkg::GRANULE + scpa_pkg::GRANULE), e);
    issue_request(alloc_req(cls * scpa_pkg::GRANULE + scpa_pkg::GRANULE), e);
  endtask

  task automatic test_random_mix(int n);
    scpa_pkg::req_t r;
    scpa_pkg::rsp_t e;
    int             pick;
    int             idx;
    int             cls;
    int             bsize;
    logic [15:0]    a;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        r = alloc_req($urandom_range(1, scpa_pkg::MAX_SMALL));
      end else if (pick < 55) begin
        r = alloc_req(($urandom_range(0, 3) == 0) ?
                      0 : $urandom_range(scpa_pkg::MAX_SMALL + 1, 65535));
      end else if (pick < 85 && held_blocks.size() > 0) begin
        idx = $urandom_range(0, held_blocks.size() - 1);
        a = held_blocks[idx];
        held_blocks.delete(idx);
        r = free_req(a);
      end else if (pick < 93) begin
        cls = $urandom_range(0, NUM_CLASSES - 1);
        bsize = (cls + 1) * scpa_pkg::GRANULE;
        r = free_req(16'(cls * CLASS_BYTES
                         + $urandom_range(0, CLASS_BYTES / bsize - 1) * bsize));
      end else begin
        r = free_req(16'($urandom));
      end
      issue_request(r, e);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      bump_off[i] = 0;
      free_head[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_alloc_edges();
    test_bad_sizes();
    test_free_reuse();
    test_misaligned_frees();
    test_exhaust_class(NUM_CLASSES - 1);
    test_exhaust_class($urandom_range(9, 14));
    test_random_mix(1000);

    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
